>>> rtl/core/ldf_pkg.sv
package ldf_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned CntW        = 4;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [CntW-1:0]    PrefixBytes = CntW'(8);
  localparam logic [CntW-1:0]    WordBytes   = CntW'(4);
  localparam logic [WordW-1:0]   BodyMin     = WordW'(4);

  localparam logic [WordW-1:0]   MagicWordRst  = '0;
  localparam logic [WordW-1:0]   MaxBodyLenRst = WordW'(65536);

  localparam logic [CfgIdxW-1:0] CfgMagicWord  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMaxBodyLen = CfgIdxW'(1);

  localparam logic [1:0] StData   = 2'd0;
  localparam logic [1:0] StEmpty  = 2'd1;
  localparam logic [1:0] StMagic  = 2'd2;
  localparam logic [1:0] StLength = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [ByteW-1:0] data_byte;
  } ldf_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ByteW-1:0] data_out;
    logic             is_payload;
    logic             last;
  } ldf_out_t;

  typedef struct packed {
    logic [WordW-1:0] magic_word;
    logic [WordW-1:0] max_body_len;
  } ldf_cfg_t;

endpackage

>>> rtl/core/ldf_cfg_regs.sv
module ldf_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [ldf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ldf_pkg::WordW-1:0]   cfg_data_i,
  output ldf_pkg::ldf_cfg_t       cfg_o
);
  import ldf_pkg::*;

  ldf_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgMagicWord:  cfg_d.magic_word   = cfg_data_i;
        CfgMaxBodyLen: cfg_d.max_body_len = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word   <= MagicWordRst;
      cfg_q.max_body_len <= MaxBodyLenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> rtl/core/ldf_parser.sv
module ldf_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldf_pkg::ldf_cfg_t cfg_i,
  input  logic              item_valid_i,
  input  ldf_pkg::ldf_in_t  item_i,
  output logic              result_valid_o,
  output ldf_pkg::ldf_out_t result_o
);
  import ldf_pkg::*;

  localparam logic [1:0] PhPrefix  = 2'd0;
  localparam logic [1:0] PhHlen    = 2'd1;
  localparam logic [1:0] PhHeader  = 2'd2;
  localparam logic [1:0] PhPayload = 2'd3;

  logic [1:0]       phase_q, phase_d;
  logic [CntW-1:0]  prefix_count_q, prefix_count_d;
  logic [WordW-1:0] word_shift_q, word_shift_d;
  logic [WordW-1:0] magic_seen_q, magic_seen_d;
  logic [WordW-1:0] body_rem_q, body_rem_d;
  logic [WordW-1:0] header_left_q, header_left_d;
  logic [WordW-1:0] payload_left_q, payload_left_d;
  logic             halted_q, halted_d;

  logic [WordW-1:0] shifted;
  logic [CntW-1:0]  cnt_inc;
  logic [WordW-1:0] header_dec;
  logic [WordW-1:0] payload_dec;

  assign shifted     = {item_i.data_byte, word_shift_q[WordW-1:ByteW]};
  assign cnt_inc     = prefix_count_q + CntW'(1);
  assign header_dec  = header_left_q - WordW'(1);
  assign payload_dec = payload_left_q - WordW'(1);

  always_comb begin
    phase_d        = phase_q;
    prefix_count_d = prefix_count_q;
    word_shift_d   = word_shift_q;
    magic_seen_d   = magic_seen_q;
    body_rem_d     = body_rem_q;
    header_left_d  = header_left_q;
    payload_left_d = payload_left_q;
    halted_d       = halted_q;
    result_valid_o = 1'b0;
    result_o       = '{status: StData, data_out: '0, is_payload: 1'b0, last: 1'b1};

    if (item_valid_i) begin
      if (item_i.req_type) begin
        phase_d        = PhPrefix;
        prefix_count_d = '0;
        word_shift_d   = '0;
        magic_seen_d   = '0;
        body_rem_d     = '0;
        header_left_d  = '0;
        payload_left_d = '0;
        halted_d       = 1'b0;
      end else if (!halted_q) begin
        case (phase_q)
          PhPrefix: begin
            word_shift_d   = shifted;
            prefix_count_d = cnt_inc;
            if (cnt_inc == WordBytes) begin
              magic_seen_d = shifted;
            end
            if (cnt_inc == PrefixBytes) begin
              prefix_count_d = '0;
              word_shift_d   = '0;
              body_rem_d     = shifted - BodyMin;
              if (magic_seen_q != cfg_i.magic_word) begin
                halted_d        = 1'b1;
                result_valid_o  = 1'b1;
                result_o.status = StMagic;
              end else if (shifted < BodyMin || shifted > cfg_i.max_body_len) begin
                halted_d        = 1'b1;
                result_valid_o  = 1'b1;
                result_o.status = StLength;
              end else begin
                phase_d = PhHlen;
              end
            end
          end
          PhHlen: begin
            word_shift_d   = shifted;
            prefix_count_d = cnt_inc;
            if (cnt_inc == WordBytes) begin
              prefix_count_d = '0;
              word_shift_d   = '0;
              if (shifted > body_rem_q) begin
                halted_d        = 1'b1;
                result_valid_o  = 1'b1;
                result_o.status = StLength;
              end else begin
                header_left_d  = shifted;
                payload_left_d = body_rem_q - shifted;
                if (shifted != '0) begin
                  phase_d = PhHeader;
                end else if (body_rem_q != shifted) begin
                  phase_d = PhPayload;
                end else begin
                  phase_d         = PhPrefix;
                  result_valid_o  = 1'b1;
                  result_o.status = StEmpty;
                end
              end
            end
          end
          PhHeader: begin
            header_left_d     = header_dec;
            result_valid_o    = 1'b1;
            result_o.data_out = item_i.data_byte;
            result_o.last     = 1'b0;
            if (header_dec != '0) begin
              phase_d = PhHeader;
            end else if (payload_left_q != '0) begin
              phase_d = PhPayload;
            end else begin
              phase_d       = PhPrefix;
              result_o.last = 1'b1;
            end
          end
          PhPayload: begin
            payload_left_d      = payload_dec;
            result_valid_o      = 1'b1;
            result_o.data_out   = item_i.data_byte;
            result_o.is_payload = 1'b1;
            result_o.last       = 1'b0;
            if (payload_dec == '0) begin
              phase_d       = PhPrefix;
              result_o.last = 1'b1;
            end
          end
          default: begin
            phase_d        = PhPrefix;
            prefix_count_d = '0;
            word_shift_d   = '0;
            magic_seen_d   = '0;
            body_rem_d     = '0;
            header_left_d  = '0;
            payload_left_d = '0;
            halted_d       = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhPrefix;
      prefix_count_q <= '0;
      word_shift_q   <= '0;
      magic_seen_q   <= '0;
      body_rem_q     <= '0;
      header_left_q  <= '0;
      payload_left_q <= '0;
      halted_q       <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      prefix_count_q <= prefix_count_d;
      word_shift_q   <= word_shift_d;
      magic_seen_q   <= magic_seen_d;
      body_rem_q     <= body_rem_d;
      header_left_q  <= header_left_d;
      payload_left_q <= payload_left_d;
      halted_q       <= halted_d;
    end
  end

  a_payload_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPayload) |-> (header_left_q == '0 && payload_left_q != '0))
    else $error("payload phase entered with header bytes pending or no payload");

  a_data_phase_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHeader || phase_q == PhPayload) |->
      (prefix_count_q == '0 && word_shift_q == '0))
    else $error("prefix collection state left over in a data phase");

  a_prefix_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prefix_count_q < PrefixBytes)
    else $error("prefix byte count out of range");

  a_status_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != StData) |->
      (result_o.last && result_o.data_out == '0 && !result_o.is_payload))
    else $error("non-data result without last mark or with data");

  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status == StMagic || result_o.status == StLength))
      |=> halted_q)
    else $error("error reported without halting the parser");

endmodule

>>> rtl/core/length_prefixed_deframer_core.sv
// Frame parser for a byte stream laid out as a little-endian magic word, a
// body length and a header length, followed by header and payload bytes. One
// input transaction carries one received byte or a clear request; each header
// or payload byte gives one result flagged as header or payload, with last set
// on the final byte of a frame, and an empty frame, a bad magic word or a bad
// length each give a single status result. After an error all bytes are dropped
// without a result until a clear request arrives. The block takes a transaction
// per clock cycle unless the consumer stalls, through an input register, the
// parse logic and a result register that lets the next byte enter while a
// finished result waits for the consumer. The user must write registers through
// the configuration port only while no transaction is in flight (not enforced).
module length_prefixed_deframer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ldf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ldf_pkg::WordW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  ldf_pkg::ldf_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ldf_pkg::ldf_out_t           out_data_o
);
  import ldf_pkg::*;

  ldf_cfg_t cfg;
  logic     s1_valid_q;
  ldf_in_t  s1_item_q;
  logic     out_valid_q;
  ldf_out_t out_data_q;
  logic     advance;
  logic     res_valid;
  ldf_out_t res;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  ldf_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ldf_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .item_valid_i   (advance),
    .item_i         (s1_item_q),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

endmodule
